[rtl/core/ltm_pkg.sv]
// Package for the like-term merge table: status codes and the shared
// cell-chain control types. No dependencies.
package ltm_pkg;

  localparam int COEF_W   = 32;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int VID_W    = 8;

  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_MERGED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_SCAN  = 2'd1,
    FSM_MOD   = 2'd2,
    FSM_OUT   = 2'd3
  } fsm_t;

  // token walking down the chain of cells during a search
  typedef struct packed {
    logic tok;    // search token at this cell
    logic found;  // an earlier cell already matched
  } ltm_tok_t;

endpackage

[rtl/core/ltm_cell.sv]
// One table entry of the like-term merge table: key, coefficient, valid.
// Depends on ltm_pkg.
module ltm_cell #(
  parameter int KEY_W = 262
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 wr_en,
  input  logic [KEY_W-1:0]     wr_key,
  input  logic [31:0]          wr_coef,
  input  logic                 coef_en,
  input  logic [31:0]          coef_val,
  input  logic [KEY_W-1:0]     srch_key,
  input  ltm_pkg::ltm_tok_t    tok_in,
  output ltm_pkg::ltm_tok_t    tok_out,
  output logic                 hit,
  output logic                 vld,
  output logic [31:0]          coef
);
  import ltm_pkg::*;

  logic             vld_r;
  logic [KEY_W-1:0] key_r;
  logic [31:0]      coef_r;
  ltm_tok_t         tok_r;

  // hit only when the token reaches this cell and nothing earlier matched
  assign hit     = tok_in.tok && !tok_in.found && vld_r && (key_r == srch_key);
  assign vld     = vld_r;
  assign coef    = coef_r;
  assign tok_out = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= 1'b0;
      tok_r <= '0;
    end else begin
      tok_r.tok   <= tok_in.tok;
      tok_r.found <= tok_in.found || hit;
      if (wr_en) vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r  <= wr_key;
      coef_r <= wr_coef;
    end else if (coef_en) begin
      coef_r <= coef_val;
    end
  end

endmodule

[rtl/core/ltm_modadd.sv]
// Iterative modular add: (a + b) mod m, one conditional subtract of a
// shifted modulus per cycle. Depends on ltm_pkg.
module ltm_modadd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] m,
  output logic        done,
  output logic [31:0] res
);
  import ltm_pkg::*;

  logic [32:0] rem_r, rem_nxt;
  logic [64:0] div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        zmod_r, zmod_nxt;

  // 33 steps: the divisor runs from m << 32 down to m << 0
  always_comb begin
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zmod_nxt = zmod_r;
    if (go) begin
      rem_nxt  = {1'b0, a} + {1'b0, b};
      div_nxt  = {1'b0, m, 32'd0};
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
      zmod_nxt = (m == 32'd0);
    end else if (busy_r) begin
      if (!zmod_r && ({32'd0, rem_r} >= div_r)) rem_nxt = 33'(({32'd0, rem_r} - div_r));
      div_nxt = div_r >> 1;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    cnt_r  <= cnt_nxt;
    zmod_r <= zmod_nxt;
  end

  assign done = done_r;
  assign res  = rem_r[31:0];

endmodule

[rtl/core/like_term_merge_table.sv]
// Top level of the like-term merge table: term accumulator, chain of entry
// cells searched by a walking token, and the sequencing control.
// Depends on ltm_pkg, ltm_cell and ltm_modadd.
//
//  channel | direction | handshake     | words
//  in_*    | input     | valid / stall | one vertex per word
//  out_*   | output    | valid / stall | one result per finished or empty term
//  cfg_*   | input     | valid / ready | modulus
//
// A word without last_vertex leaves the input free; an empty term holds the
// input until its result has gone. A finished term walks a token down the
// MAX_TERMS cells, one cell a cycle, in the scan state; on a match a merge
// then runs the shift-subtract modulus unit. The input is held after every
// finished term, whether it appends, is dropped or merges, until its result
// has gone.
// Reset is synchronous, active low; it empties the table and the term.
// The output register holds its word under out_stall; no new word is taken
// until the result has gone.
module like_term_merge_table #(
  parameter int MAX_TERMS    = 64,
  parameter int MAX_VERTEX   = 256,
  parameter int MAX_DIM      = 32,
  parameter int BITMAP_WORDS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_set,
  input  logic        in_empty_term,
  input  logic [7:0]  in_vertex_id,
  input  logic [31:0] in_coefficient,
  input  logic        in_last_vertex,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_slot,
  output logic [31:0] out_slot_coefficient,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_coef_modulus
);
  import ltm_pkg::*;

  localparam int BM_W  = 64 * BITMAP_WORDS;
  localparam int DIM_W = 6;
  localparam int KEY_W = BM_W + DIM_W;
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  fsm_t state_r, state_nxt;

  logic [31:0]      mod_r;
  logic [BM_W-1:0]  bm_r, bm_nxt;
  logic [DIM_W-1:0] dim_r, dim_nxt;
  logic [31:0]      tcoef_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] scan_r;
  logic [CNT_W:0]   step_r;
  logic             found_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [31:0]      hit_coef_r;

  logic        ov_r;
  logic [5:0]  os_r;
  logic [31:0] oc_r;
  logic [1:0]  ost_r;

  logic acc, fin, clr_tab, scan_go, cell_wr, cell_upd, ma_go, ma_done;
  logic [31:0] ma_res;

  ltm_tok_t          tok [MAX_TERMS+1];
  ltm_tok_t          tok0_r;
  logic [MAX_TERMS-1:0] hit_v, vld_v;
  logic [31:0]       coef_v [MAX_TERMS];
  logic [KEY_W-1:0]  skey_r;

  assign cfg_ready = (state_r == FSM_IDLE) && !ov_r;
  assign in_stall  = (state_r != FSM_IDLE) || ov_r;
  assign acc       = in_valid && !in_stall;

  // term accumulator: drop vertices past MAX_DIM, ids that are zero or out of range add dim only
  always_comb begin
    bm_nxt  = in_start_set ? '0 : bm_r;
    dim_nxt = in_start_set ? '0 : dim_r;
    if (in_empty_term) begin
      bm_nxt  = '0;
      dim_nxt = '0;
    end else if (32'(dim_nxt) < MAX_DIM) begin
      dim_nxt = dim_nxt + 6'd1;
      if (in_vertex_id != 8'd0 && 32'(in_vertex_id) < MAX_VERTEX &&
          32'(in_vertex_id >> 6) < BITMAP_WORDS)
        bm_nxt[in_vertex_id] = 1'b1;
    end
  end

  assign fin     = acc && !in_empty_term && in_last_vertex;
  assign clr_tab = acc && in_start_set;
  assign scan_go = fin;
  assign tok[0]  = '{tok: scan_go, found: 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= 32'hFFFF_FFFF;
      bm_r  <= '0;
      dim_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) mod_r <= cfg_coef_modulus;
      if (acc) begin
        bm_r  <= bm_nxt;
        dim_r <= dim_nxt;
      end
      if (cell_wr || cell_upd || (state_r == FSM_SCAN && state_nxt == FSM_OUT)) begin
        bm_r  <= '0;
        dim_r <= '0;
      end
    end
  end

  // search key is taken from the next-state accumulator on the finishing word
  always_ff @(posedge clk) begin
    if (fin) begin
      skey_r  <= {dim_nxt, bm_nxt};
      tcoef_r <= in_coefficient;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_TERMS; g++) begin : g_cell
      ltm_cell #(.KEY_W(KEY_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (clr_tab),
        .wr_en    (cell_wr && scan_r == IDX_W'(g)),
        .wr_key   (skey_r),
        .wr_coef  (tcoef_r),
        .coef_en  (cell_upd && hit_idx_r == IDX_W'(g)),
        .coef_val (ma_res),
        .srch_key (skey_r),
        .tok_in   (g == 0 ? tok0_r : tok[g]),
        .tok_out  (tok[g+1]),
        .hit      (hit_v[g]),
        .vld      (vld_v[g]),
        .coef     (coef_v[g])
      );
    end
  endgenerate

  // token registered together with the search key, on the finishing word
  always_ff @(posedge clk) begin
    if (!rst_n) tok0_r <= '0;
    else        tok0_r <= tok[0];
  end

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: if (fin) state_nxt = FSM_SCAN;
      FSM_SCAN: if (32'(step_r) == MAX_TERMS + 1)
                  state_nxt = found_r ? FSM_MOD : FSM_OUT;
      FSM_MOD:  if (ma_done) state_nxt = FSM_OUT;
      FSM_OUT:  state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    cell_wr  = 1'b0;
    cell_upd = 1'b0;
    ma_go    = 1'b0;
    case (state_r)
      FSM_SCAN: begin
        if (32'(step_r) == MAX_TERMS + 1) begin
          ma_go   = found_r;
          cell_wr = !found_r && (32'(cnt_r) < MAX_TERMS);
        end
      end
      FSM_MOD:  cell_upd = ma_done;
      default: ;
    endcase
  end

  assign scan_r = cnt_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_tab) cnt_r <= '0;
      if (cell_wr) cnt_r <= cnt_r + CNT_W'(1);
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (acc && in_empty_term) ov_r <= 1'b1;
      if (state_r == FSM_SCAN && state_nxt == FSM_OUT) ov_r <= 1'b1;
      if (cell_upd) ov_r <= 1'b1;
    end
  end

  // scan bookkeeping: catch the single hit as the token passes
  always_ff @(posedge clk) begin
    if (fin) begin
      step_r  <= '0;
      found_r <= 1'b0;
    end else if (state_r == FSM_SCAN) begin
      step_r <= step_r + (CNT_W+1)'(1);
      for (int k = 0; k < MAX_TERMS; k++) begin
        if (hit_v[k]) begin
          found_r    <= 1'b1;
          hit_idx_r  <= IDX_W'(k);
          hit_coef_r <= coef_v[k];
        end
      end
    end
  end

  ltm_modadd u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (ma_go),
    .a    (hit_coef_r),
    .b    (tcoef_r),
    .m    (mod_r),
    .done (ma_done),
    .res  (ma_res)
  );

  // output register: hold under stall
  always_ff @(posedge clk) begin
    if (acc && in_empty_term) begin
      os_r <= '0; oc_r <= '0; ost_r <= ST_EMPTY;
    end else if (cell_upd) begin
      os_r <= 6'(hit_idx_r); oc_r <= ma_res; ost_r <= ST_MERGED;
    end else if (cell_wr) begin
      os_r <= 6'(scan_r); oc_r <= tcoef_r; ost_r <= ST_APPENDED;
    end else if (state_r == FSM_SCAN && state_nxt == FSM_OUT) begin
      os_r <= '0; oc_r <= '0; ost_r <= ST_FULL;
    end
  end

  assign out_valid            = ov_r;
  assign out_slot             = os_r;
  assign out_slot_coefficient = oc_r;
  assign out_status           = ost_r;

  // a result word is never replaced while it is waiting
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(os_r) && $stable(ost_r))
    else $error("result word changed under stall");
  a_nofill: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MAX_TERMS) else $error("entry count overflow");
  a_onehit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_v)) else $error("two cells matched");
  a_vldcnt: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_v) == 32'(cnt_r)) else $error("valid cells disagree with count");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for like_term_merge_table: table-driven directed terms, then random
// sparse-polynomial terms checked against an in-bench merge-table predictor.
// Depends on ltm_pkg and the RTL of like_term_merge_table.
module tb_top;
  import ltm_pkg::*;

  localparam int N_TERMS  = 64;
  localparam int N_VERTEX = 256;
  localparam int N_DIM    = 32;
  localparam int N_WORDS  = 4;
  localparam int N_RANDOM = 750;
  localparam logic [31:0] MOD_RESET = 32'hFFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_start_set;
  logic        in_empty_term;
  logic [7:0]  in_vertex_id;
  logic [31:0] in_coefficient;
  logic        in_last_vertex;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_slot;
  logic [31:0] out_slot_coefficient;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_coef_modulus;

  like_term_merge_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_set(in_start_set), .in_empty_term(in_empty_term),
    .in_vertex_id(in_vertex_id), .in_coefficient(in_coefficient),
    .in_last_vertex(in_last_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_slot(out_slot), .out_slot_coefficient(out_slot_coefficient),
    .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_coef_modulus(cfg_coef_modulus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One vertex word as offered on the input channel.
  typedef struct {
    logic        start_set;
    logic        empty_term;
    logic [7:0]  vertex_id;
    logic [31:0] coefficient;
    logic        last_vertex;
  } vertex_word_t;

  // One result word.
  typedef struct {
    logic [5:0]  slot;
    logic [31:0] slot_coef;
    status_t     status;
  } merge_result_t;

  // Predictor copy of the table and of the term being gathered.
  logic [63:0] tbl_bitmap [N_TERMS][N_WORDS];
  logic [5:0]  tbl_dim    [N_TERMS];
  logic [31:0] tbl_coef   [N_TERMS];
  int          tbl_count;
  logic [63:0] acc_bitmap [N_WORDS];
  int          acc_dim;
  logic [31:0] modulus;

  merge_result_t pending_results[$];
  int          n_mismatch;
  int          n_results;
  int          n_merged;
  int          n_full;
  int          n_accepted;
  bit          hold_off;

  function automatic logic [31:0] mod_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (modulus == 32'd0) return s[31:0];
    return 32'(s % {1'b0, modulus});
  endfunction

  function automatic void clear_acc();
    for (int w = 0; w < N_WORDS; w++) acc_bitmap[w] = '0;
    acc_dim = 0;
  endfunction

  // Work out what one accepted word causes and queue it.
  function automatic void predict_merge(vertex_word_t v);
    merge_result_t r;
    bit same;
    if (v.start_set) begin
      tbl_count = 0;
      clear_acc();
    end
    if (v.empty_term) begin
      clear_acc();
      r = '{6'd0, 32'd0, ST_EMPTY};
      pending_results.push_back(r);
      return;
    end
    if (acc_dim < N_DIM) begin
      acc_dim++;
      if (v.vertex_id != 0 && v.vertex_id < N_VERTEX && (v.vertex_id >> 6) < N_WORDS)
        acc_bitmap[v.vertex_id >> 6][v.vertex_id[5:0]] = 1'b1;
    end
    if (!v.last_vertex) return;
    for (int i = 0; i < tbl_count; i++) begin
      same = (tbl_dim[i] == 6'(acc_dim));
      for (int w = 0; w < N_WORDS; w++)
        if (tbl_bitmap[i][w] != acc_bitmap[w]) same = 0;
      if (same) begin
        tbl_coef[i] = mod_sum(tbl_coef[i], v.coefficient);
        clear_acc();
        r = '{6'(i), tbl_coef[i], ST_MERGED};
        pending_results.push_back(r);
        return;
      end
    end
    if (tbl_count >= N_TERMS) begin
      clear_acc();
      r = '{6'd0, 32'd0, ST_FULL};
      pending_results.push_back(r);
      return;
    end
    tbl_dim[tbl_count]  = 6'(acc_dim);
    tbl_coef[tbl_count] = v.coefficient;
    for (int w = 0; w < N_WORDS; w++) tbl_bitmap[tbl_count][w] = acc_bitmap[w];
    r = '{6'(tbl_count), v.coefficient, ST_APPENDED};
    pending_results.push_back(r);
    tbl_count++;
    clear_acc();
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word, hold it until taken, then run it through the predictor.
  task automatic send_word(vertex_word_t v);
    in_valid       <= 1'b1;
    in_start_set   <= v.start_set;
    in_empty_term  <= v.empty_term;
    in_vertex_id   <= v.vertex_id;
    in_coefficient <= v.coefficient;
    in_last_vertex <= v.last_vertex;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_merge(v);
    n_accepted++;
  endtask

  // Drop valid only when a gap follows, so valid is never lowered and raised in one step.
  task automatic send_gapped(vertex_word_t v, int gap);
    send_word(v);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // all results are out; idle before the next phase
    repeat (N_TERMS + 60) @(posedge clk);
  endtask

  task automatic write_modulus(logic [31:0] m);
    cfg_valid        <= 1'b1;
    cfg_coef_modulus <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    modulus = m;
  endtask

  // Send one whole term: dim vertices drawn from ids 0..pool, or from all ids when pool is 0, so terms repeat.
  task automatic send_term(bit start, int dim, int pool, logic [31:0] coef);
    vertex_word_t v;
    for (int k = 0; k < dim; k++) begin
      v.start_set   = start && (k == 0);
      v.empty_term  = 1'b0;
      v.vertex_id   = (pool == 0) ? 8'($urandom) : 8'($urandom_range(0, pool));
      v.coefficient = $urandom;
      v.last_vertex = (k == dim - 1);
      if (v.last_vertex) v.coefficient = coef;
      send_gapped(v, gap_len());
    end
  endtask

  // Result side: stall at random, with one long hold-off on demand.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  // Check every accepted result word against the oldest expectation.
  always @(posedge clk) begin
    merge_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result slot=%0d coef=%h status=%0d",
                   out_slot, out_slot_coefficient, out_status);
      end else begin
        e = pending_results.pop_front();
        if (e.status == ST_MERGED) n_merged++;
        if (e.status == ST_FULL) n_full++;
        if (out_slot !== e.slot || out_slot_coefficient !== e.slot_coef ||
            out_status !== e.status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected slot=%0d coef=%h status=%0d, %s%0d %s%h %s%0d",
                     e.slot, e.slot_coef, e.status,
                     "got slot=", out_slot, "coef=", out_slot_coefficient,
                     "status=", out_status);
        end
      end
    end
  end

  // Long receiver hold-off, counted in its own process, while words keep coming.
  task automatic long_hold();
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  endtask

  // Directed rows: start, empty, vertex, coefficient, last; expected status
  // typed in where plain, otherwise left to the predictor.
  typedef struct {
    vertex_word_t w;
    bit           typed;
    merge_result_t r;
  } directed_row_t;

  directed_row_t rows[$];

  task automatic build_rows();
    directed_row_t d;
    d.typed = 0; d.r = '{6'd0, 32'd0, ST_APPENDED};
    // single vertex 0 term straight after reset: append into slot 0
    d.w = '{1'b0, 1'b0, 8'd0, 32'hFFFF_FFFF, 1'b1}; d.typed = 1;
    d.r = '{6'd0, 32'hFFFF_FFFF, ST_APPENDED}; rows.push_back(d);
    // the same term again merges: (max + max) mod max = 0
    d.w = '{1'b0, 1'b0, 8'd0, 32'hFFFF_FFFF, 1'b1};
    d.r = '{6'd0, 32'd0, ST_MERGED}; rows.push_back(d);
    // empty term, last clear
    d.w = '{1'b0, 1'b1, 8'hFF, 32'h1234_5678, 1'b0};
    d.r = '{6'd0, 32'd0, ST_EMPTY}; rows.push_back(d);
    d.typed = 0;
    // two-vertex term with highest id, then an empty word with last set dropping a partial term
    d.w = '{1'b0, 1'b0, 8'd255, 32'd0, 1'b0}; rows.push_back(d);
    d.w = '{1'b0, 1'b0, 8'd1, 32'd7, 1'b1}; rows.push_back(d);
    d.w = '{1'b0, 1'b0, 8'd64, 32'd0, 1'b0}; rows.push_back(d);
    d.w = '{1'b0, 1'b1, 8'd0, 32'd0, 1'b1}; d.typed = 1;
    d.r = '{6'd0, 32'd0, ST_EMPTY}; rows.push_back(d);
    d.typed = 0;
    // same ids in the other order: 1,255 matches the 255,1 term in slot 1
    d.w = '{1'b0, 1'b0, 8'd1, 32'd0, 1'b0}; rows.push_back(d);
    d.w = '{1'b0, 1'b0, 8'd255, 32'd9, 1'b1}; rows.push_back(d);
    d.w = '{1'b0, 1'b0, 8'd128, 32'hAAAA_5555, 1'b1}; rows.push_back(d);
    d.w = '{1'b0, 1'b0, 8'd192, 32'h5555_AAAA, 1'b1}; rows.push_back(d);
    // start_set with a finished term: table restarts at slot 0
    d.w = '{1'b1, 1'b0, 8'd63, 32'd5, 1'b1}; d.typed = 1;
    d.r = '{6'd0, 32'd5, ST_APPENDED}; rows.push_back(d);
    // start_set with an empty term
    d.w = '{1'b1, 1'b1, 8'd0, 32'd0, 1'b0};
    d.r = '{6'd0, 32'd0, ST_EMPTY}; rows.push_back(d);
    d.typed = 0;
  endtask

  // Overlong term (beyond the dimension limit), then single-vertex terms
  // until the table is full and further terms are dropped.
  task automatic run_limits();
    vertex_word_t v;
    for (int k = 0; k < 40; k++) begin
      v = '{(k == 0), 1'b0, 8'(k * 7 + 1), 32'd3, (k == 39)};
      send_gapped(v, gap_len());
    end
    for (int k = 0; k < 66; k++) begin
      v = '{1'b0, 1'b0, 8'(k + 1), 32'(k), 1'b1};
      send_gapped(v, gap_len());
    end
  endtask

  task automatic random_phase(int n_words);
    int sent;
    int p;
    vertex_word_t v;
    sent = 0;
    while (sent < n_words) begin
      p = $urandom_range(0, 99);
      if (p < 75) begin
        // well-formed term, small vertex pool to force merges
        int dim;
        dim = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 4);
        send_term(($urandom_range(0, 29) == 0), dim,
                  ($urandom_range(0, 3) == 0) ? 0 : 6,
                  ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                              : $urandom);
        sent += dim;
      end else begin
        v.start_set   = ($urandom_range(0, 19) == 0);
        v.empty_term  = ($urandom_range(0, 2) == 0);
        v.vertex_id   = $urandom;
        v.coefficient = $urandom;
        v.last_vertex = $urandom_range(0, 1);
        send_gapped(v, gap_len());
        sent++;
      end
    end
  endtask

  initial begin
    logic [31:0] mods [6];
    merge_result_t last_r;
    int gap;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_start_set     = 1'b0;
    in_empty_term    = 1'b0;
    in_vertex_id     = '0;
    in_coefficient   = '0;
    in_last_vertex   = 1'b0;
    cfg_valid        = 1'b0;
    cfg_coef_modulus = '0;
    hold_off         = 1'b0;
    n_mismatch = 0; n_results = 0; n_merged = 0; n_full = 0; n_accepted = 0;
    tbl_count = 0; modulus = MOD_RESET;
    clear_acc();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; typed rows are checked against the typed expectation too,
    // straight after acceptance while the newest expectation is still queued.
    build_rows();
    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].typed) begin
        last_r = pending_results[$];
        if (last_r.slot != rows[i].r.slot || last_r.slot_coef != rows[i].r.slot_coef ||
            last_r.status != rows[i].r.status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("directed row %0d: predictor disagrees with table", i);
        end
      end
      gap = gap_len();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    run_limits();
    drain();

    // Modulus settings, extremes among them; pause until idle before each write.
    mods = '{32'd2, 32'hFFFF_FFFF, 32'd3, 32'h8000_0001, 32'd1000, 32'hFFFF_FFFE};
    foreach (mods[m]) begin
      write_modulus(mods[m]);
      if (m == 1) begin
        fork
          long_hold();
          random_phase(60);
        join
      end else begin
        random_phase(N_RANDOM / 6);
      end
      drain();
    end

    $display("covered %0d words, %0d results (%0d merged, %0d full) over %0d moduli",
             n_accepted, n_results, n_merged, n_full, 7);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("mismatches: %0d, left over: %0d", n_mismatch, pending_results.size());
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(64'd40_000_000);
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ltm_pkg.sv
rtl/core/ltm_cell.sv
rtl/core/ltm_modadd.sv
rtl/core/like_term_merge_table.sv
bench/tb_top.sv
